// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/rdwf_pkg.sv -----
// ----------------------------------------------------------------------------
// rdwf_pkg
// Types, codes and helper functions of the duplicate window forwarder.
// ----------------------------------------------------------------------------
`default_nettype none

package rdwf_pkg;

  localparam logic [7:0] WAIT_MIN = 8'd61;
  localparam logic [7:0] WAIT_MAX = 8'd183;
  localparam logic [7:0] SAT8     = 8'd255;
  localparam logic [3:0] AGE_MAX  = 4'd15;
  localparam logic [4:0] MAX_RESULTS = 5'd16;

  localparam logic [7:0] OWN_LEVEL_RST = 8'd255;
  localparam logic       IS_GATEWAY_RST = 1'b0;
  localparam logic [7:0] MARGIN_RST    = 8'd1;
  localparam logic [7:0] HOP_LIMIT_RST = 8'd5;

  typedef enum logic [3:0] {
    EV_SUNK            = 4'd0,
    EV_DUP_BUFFERED    = 4'd1,
    EV_DUP_IGNORED     = 4'd2,
    EV_HOP_DROP        = 4'd3,
    EV_WINDOW_OPEN     = 4'd4,
    EV_TABLE_FULL      = 4'd5,
    EV_FORWARDED       = 4'd6,
    EV_SPATIAL_DISCARD = 4'd7,
    EV_FILTER_DISCARD  = 4'd8
  } event_t;

  typedef enum logic [1:0] {
    REG_OWN_LEVEL      = 2'd0,
    REG_IS_GATEWAY     = 2'd1,
    REG_RETREAT_MARGIN = 2'd2,
    REG_HOP_LIMIT      = 2'd3
  } reg_index_t;

  typedef enum logic {
    KIND_ARRIVAL = 1'b0,
    KIND_TICK    = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ARR_END,
    ST_TICK_END
  } state_t;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [7:0]  ticks_left;
    logic [7:0]  best_hops;
    logic [7:0]  best_level;
    logic [7:0]  tie_count;
  } entry_t;

  typedef struct packed {
    event_t      ev;
    logic [31:0] frame_id;
    logic [7:0]  hop_count;
    logic [7:0]  level;
  } result_t;

  // Fold one candidate into an entry if it passes the retreat test.
  function automatic entry_t add_candidate(entry_t e, logic [7:0] hops, logic [7:0] lvl,
                                           logic [7:0] own, logic [7:0] margin);
    entry_t     r;
    logic [8:0] sum;
    r   = e;
    sum = {1'b0, lvl} + {1'b0, margin};
    if (sum > {1'b0, own}) begin
      if (e.tie_count == 8'd0 || hops < e.best_hops) begin
        r.best_hops  = hops;
        r.best_level = lvl;
        r.tie_count  = 8'd1;
      end else if (hops == e.best_hops) begin
        if (e.tie_count != SAT8) begin
          r.tie_count = e.tie_count + 8'd1;
        end
        if (lvl > e.best_level) begin
          r.best_level = lvl;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp_wait(logic [7:0] w);
    logic [7:0] r;
    r = w;
    if (w < WAIT_MIN) begin
      r = WAIT_MIN;
    end else if (w > WAIT_MAX) begin
      r = WAIT_MAX;
    end
    return r;
  endfunction

  // Decision for a window that closes.
  function automatic result_t expire_result(entry_t e, logic [7:0] own);
    result_t r;
    r.frame_id  = e.frame_id;
    r.hop_count = 8'd0;
    r.level     = 8'd0;
    if (e.tie_count == 8'd0) begin
      r.ev = EV_SPATIAL_DISCARD;
    end else if (e.tie_count > 8'd1 && e.best_level == 8'd0) begin
      r.ev = EV_FILTER_DISCARD;
    end else begin
      r.ev        = EV_FORWARDED;
      r.hop_count = (e.best_hops == SAT8) ? SAT8 : e.best_hops + 8'd1;
      r.level     = own;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/rdwf_in_if.sv -----
// ----------------------------------------------------------------------------
// rdwf_in_if
// Input channel: packet arrivals and ticks with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdwf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [31:0] frame_id;
  logic [7:0] hop_count;
  logic [7:0] sender_level;
  logic [7:0] wait_ticks;

  modport source (output valid, kind, frame_id, hop_count, sender_level, wait_ticks,
                  input ready);
  modport sink (input valid, kind, frame_id, hop_count, sender_level, wait_ticks,
                output ready);
endinterface

`default_nettype wire

// ----- src/rdwf_out_if.sv -----
// ----------------------------------------------------------------------------
// rdwf_out_if
// Result channel: forwarding events with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdwf_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [31:0] out_frame_id;
  logic [7:0]  out_hop_count;
  logic [7:0]  out_level;
  logic        last;

  modport source (output valid, event_res, out_frame_id, out_hop_count, out_level, last,
                  input ready);
  modport sink (input valid, event_res, out_frame_id, out_hop_count, out_level, last,
                output ready);
endinterface

`default_nettype wire

// ----- src/relay_duplicate_window_forwarder.sv -----
// ----------------------------------------------------------------------------
// relay_duplicate_window_forwarder
// Flood-forwarding decision of a relay with a duplicate-collection window.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Every packet arrival (except on a
// gateway node) and every tick walks the frame table once through a single
// read port of the entry memory, one entry per cycle unless a tick stalls it,
// and ready stays low from the transfer until the block is back in idle; a
// gateway arrival skips the walk and goes straight to its final step. A full
// output register holds an arrival at its final step until the consumer takes
// the previous result. A tick that closes several windows emits one result per
// closed window in table order and stalls the walk whenever a result is still
// waiting on a full output register, so a slow consumer stretches the tick.
// Arrivals always give exactly one result with last set. Config writes land at
// once and are meant for idle periods only. No clearing pass is needed after
// reset: valid, open and age bits sit in flops that reset clears.
`default_nettype none
`include "assert_macros.svh"

module relay_duplicate_window_forwarder #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [1:0]              wr_index,
  input  logic [7:0]              wr_data,
  rdwf_in_if.sink                 item,
  rdwf_out_if.source              result
);
  import rdwf_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  // Configuration registers.
  logic [7:0] own_level;
  logic       is_gateway;
  logic [7:0] margin;
  logic [7:0] hop_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_level  <= OWN_LEVEL_RST;
      is_gateway <= IS_GATEWAY_RST;
      margin     <= MARGIN_RST;
      hop_limit  <= HOP_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_OWN_LEVEL:      own_level  <= wr_data;
        REG_IS_GATEWAY:     is_gateway <= wr_data[0];
        REG_RETREAT_MARGIN: margin     <= wr_data;
        REG_HOP_LIMIT:      hop_limit  <= wr_data;
        default: ;
      endcase
    end
  end

  // Current item, captured on transfer.
  logic        cur_tick;
  logic [31:0] cur_fid;
  logic [7:0]  cur_hops;
  logic [7:0]  cur_lvl;
  logic [7:0]  cur_wait;

  state_t state, state_next;

  // Walk pointers: ia issues the read, q/q_idx hold the entry read last cycle.
  logic [IW-1:0] ia;
  logic          iss;
  logic [IW-1:0] q_idx;
  logic          q_vld;
  entry_t        q;

  entry_t mem [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] wopen;
  logic [3:0]             age [TABLE_DEPTH];

  // Arrival walk results.
  logic          hit;
  logic [IW-1:0] hit_idx;
  entry_t        hit_word;
  logic          hit_open;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          old_found;
  logic [IW-1:0] old_idx;
  logic [3:0]    old_age;

  // Tick: one closed window waits in pend until we know whether it is the last.
  logic          pend_vld;
  result_t       pend;
  logic [4:0]    n_res;

  // Output register.
  logic          out_valid;
  result_t       out_res;
  logic          out_last;

  // Combinational control.
  logic          accept;
  logic          out_free;
  logic          q_v, q_o;
  logic [3:0]    q_a;
  logic          tk_live, tk_expire, stall, adv, scan_done;
  logic          slot_ok;
  logic [IW-1:0] slot;
  event_t        arr_ev;
  logic          arr_fire;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  entry_t        mem_wd;
  entry_t        new_word;
  logic          out_load;
  result_t       out_load_res;
  logic          out_load_last;

  assign accept   = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;

  assign q_v = valid[q_idx];
  assign q_o = wopen[q_idx];
  assign q_a = age[q_idx];

  // A live window on a tick either counts down, expires or is deferred.
  assign tk_live   = (state == ST_SCAN) && cur_tick && q_vld && q_v && q_o;
  assign tk_expire = tk_live && (q.ticks_left <= 8'd1) && (n_res < MAX_RESULTS);
  // Hold the walk while the previous closed window cannot move out.
  assign stall     = tk_expire && pend_vld && !out_free;
  assign adv       = !stall;
  assign scan_done = (state == ST_SCAN) && q_vld && (q_idx == LAST_IDX) && adv;

  // Replacement: lowest free entry, else the oldest closed entry.
  assign slot_ok = free_found || old_found;
  assign slot    = free_found ? free_idx : old_idx;

  always_comb begin
    new_word            = '0;
    new_word.frame_id   = cur_fid;
    new_word.ticks_left = clamp_wait(cur_wait);
    new_word            = add_candidate(new_word, cur_hops, cur_lvl, own_level, margin);
  end

  always_comb begin
    if (is_gateway) begin
      arr_ev = EV_SUNK;
    end else if (hit) begin
      arr_ev = hit_open ? EV_DUP_BUFFERED : EV_DUP_IGNORED;
    end else if (cur_hops >= hop_limit) begin
      arr_ev = EV_HOP_DROP;
    end else if (!slot_ok) begin
      arr_ev = EV_TABLE_FULL;
    end else begin
      arr_ev = EV_WINDOW_OPEN;
    end
  end

  assign arr_fire = (state == ST_ARR_END) && out_free;

  // Memory write port: tick write-back during the walk, or the arrival update.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = q_idx;
    mem_wd = q;
    if (tk_live && adv) begin
      mem_we = 1'b1;
      if (q.ticks_left > 8'd1) begin
        mem_wd.ticks_left = q.ticks_left - 8'd1;
      end else if (tk_expire) begin
        mem_wd.ticks_left = 8'd0;
      end else begin
        mem_wd.ticks_left = 8'd1;
      end
    end else if (arr_fire && arr_ev == EV_DUP_BUFFERED) begin
      mem_we = 1'b1;
      mem_wa = hit_idx;
      mem_wd = add_candidate(hit_word, cur_hops, cur_lvl, own_level, margin);
    end else if (arr_fire && arr_ev == EV_WINDOW_OPEN) begin
      mem_we = 1'b1;
      mem_wa = slot;
      mem_wd = new_word;
    end
  end

  // Output register load sources.
  always_comb begin
    out_load      = 1'b0;
    out_load_res  = pend;
    out_load_last = 1'b0;
    if (tk_expire && adv && pend_vld) begin
      out_load = 1'b1;
    end else if (state == ST_TICK_END && pend_vld && out_free) begin
      out_load      = 1'b1;
      out_load_last = 1'b1;
    end else if (arr_fire) begin
      out_load              = 1'b1;
      out_load_last         = 1'b1;
      out_load_res.ev        = arr_ev;
      out_load_res.frame_id  = cur_fid;
      out_load_res.hop_count = 8'd0;
      out_load_res.level     = 8'd0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.kind == KIND_TICK || !is_gateway) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_ARR_END;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = cur_tick ? ST_TICK_END : ST_ARR_END;
        end
      end
      ST_ARR_END: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TICK_END: begin
        if (!pend_vld || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item on transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_tick <= (item.kind == KIND_TICK);
      cur_fid  <= item.frame_id;
      cur_hops <= item.hop_count;
      cur_lvl  <= item.sender_level;
      cur_wait <= item.wait_ticks;
    end
  end

  // Entry memory: one read port for the walk, one write port.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && adv && iss) begin
      q <= mem[ia];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // Walk sequencer and arrival search.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss        <= 1'b0;
      q_vld      <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
      ia         <= '0;
    end else if (accept) begin
      ia         <= '0;
      iss        <= 1'b1;
      q_vld      <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
    end else if (state == ST_SCAN && adv) begin
      if (iss) begin
        q_idx <= ia;
        ia    <= ia + 1'b1;
        iss   <= (ia != LAST_IDX);
      end
      q_vld <= iss;
      if (q_vld && !cur_tick) begin
        if (q_v && q.frame_id == cur_fid && !hit) begin
          hit      <= 1'b1;
          hit_idx  <= q_idx;
          hit_word <= q;
          hit_open <= q_o;
        end
        if (!q_v && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= q_idx;
        end
        if (!q_o && (!old_found || q_a > old_age)) begin
          old_found <= 1'b1;
          old_idx   <= q_idx;
          old_age   <= q_a;
        end
      end
    end
  end

  // Valid, open and age flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      wopen <= '0;
      for (int e = 0; e < TABLE_DEPTH; e++) begin
        age[e] <= '0;
      end
    end else if (tk_expire && adv) begin
      wopen[q_idx] <= 1'b0;
    end else if (arr_fire && arr_ev == EV_WINDOW_OPEN) begin
      valid[slot] <= 1'b1;
      wopen[slot] <= 1'b1;
      // Age every other valid entry; the new one starts fresh.
      for (int e = 0; e < TABLE_DEPTH; e++) begin
        if (IW'(e) == slot) begin
          age[e] <= '0;
        end else if (valid[e] && age[e] != AGE_MAX) begin
          age[e] <= age[e] + 4'd1;
        end
      end
    end
  end

  // Pending closed window and result count of the tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
      n_res    <= '0;
    end else if (accept) begin
      pend_vld <= 1'b0;
      n_res    <= '0;
    end else if (tk_expire && adv) begin
      pend_vld <= 1'b1;
      pend     <= expire_result(q, own_level);
      n_res    <= n_res + 5'd1;
    end else if (state == ST_TICK_END && out_free) begin
      pend_vld <= 1'b0;
    end
  end

  // Output register: parts the walk from the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res  <= out_load_res;
      out_last <= out_load_last;
    end
  end

  assign item.ready           = (state == ST_IDLE);
  assign result.valid         = out_valid;
  assign result.event_res     = out_res.ev;
  assign result.out_frame_id  = out_res.frame_id;
  assign result.out_hop_count = out_res.hop_count;
  assign result.out_level     = out_res.level;
  assign result.last          = out_last;

  // Ready drops after every transfer.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !item.ready)
  // A held closed window only exists while a tick is in progress.
  `ASSERT_IMPLIES(a_pend_in_tick, clk, rst, pend_vld, cur_tick && (state == ST_SCAN || state == ST_TICK_END))
  // The table never changes while idle.
  `ASSERT_IMPLIES(a_write_busy, clk, rst, mem_we, state != ST_IDLE)

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the relay duplicate window forwarder. A shadow of
// the frame table predicts every event that arrivals and ticks cause, and a
// checker compares each result transfer against the oldest prediction.
// Directed tests cover the arrival outcomes, the gateway sink and the register
// extremes. Random rounds open windows, feed duplicates and tick them closed.
// ----------------------------------------------------------------------------
module testbench;
  import rdwf_pkg::*;

  localparam int DEPTH         = 16;
  // Settle time covers the worst walk over the table twice over.
  localparam int SETTLE_CYCLES = 2 * (DEPTH + 3) + 4;
  localparam int TOTAL_ITEMS   = 470;
  localparam int MAX_SHOWN     = 10;
  // Run time limit, several times the slowest legal run.
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  typedef struct {
    kind_t       kind;
    logic [31:0] frame_id;
    logic [7:0]  hops;
    logic [7:0]  level;
    logic [7:0]  wait_len;
  } relay_item_t;

  typedef struct {
    event_t      ev;
    logic [31:0] frame_id;
    logic [7:0]  hops;
    logic [7:0]  level;
    logic        last;
  } relay_event_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       wr_en;
  logic [1:0] wr_index;
  logic [7:0] wr_data;

  rdwf_in_if  item_ch ();
  rdwf_out_if result_ch ();

  relay_duplicate_window_forwarder #(
    .TABLE_DEPTH (DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item_ch),
    .result   (result_ch)
  );

  always #5 clk = ~clk;

  // Shadow registers, starting at their reset values.
  logic [7:0] own_level_sh  = OWN_LEVEL_RST;
  logic       gateway_sh    = IS_GATEWAY_RST;
  logic [7:0] margin_sh     = MARGIN_RST;
  logic [7:0] hop_limit_sh  = HOP_LIMIT_RST;

  // Shadow frame table. Valid, open and age clear at reset; the rest is only
  // read after an allocation has written it.
  bit          slot_valid      [DEPTH];
  bit          slot_open       [DEPTH];
  bit   [3:0]  slot_age        [DEPTH];
  logic [31:0] slot_fid        [DEPTH];
  logic [7:0]  slot_ticks      [DEPTH];
  logic [7:0]  slot_best_hops  [DEPTH];
  logic [7:0]  slot_best_level [DEPTH];
  logic [7:0]  slot_ties       [DEPTH];

  relay_event_t pending_events[$];
  int  items_sent = 0;
  int  mismatches = 0;
  // Set during some rounds so both sides run without gaps.
  bit  quiet_mode = 1'b0;

  // Fold one candidate into a slot if it survives the retreat test.
  function automatic void fold_candidate(int e, logic [7:0] hops, logic [7:0] lvl);
    if (int'(lvl) + int'(margin_sh) > int'(own_level_sh)) begin
      if (slot_ties[e] == 8'd0 || hops < slot_best_hops[e]) begin
        slot_best_hops[e]  = hops;
        slot_best_level[e] = lvl;
        slot_ties[e]       = 8'd1;
      end else if (hops == slot_best_hops[e]) begin
        if (slot_ties[e] != SAT8) begin
          slot_ties[e] = slot_ties[e] + 8'd1;
        end
        if (lvl > slot_best_level[e]) begin
          slot_best_level[e] = lvl;
        end
      end
    end
  endfunction

  // An arrival always yields exactly one event.
  function automatic void predict_arrival(relay_item_t it);
    int           hit;
    int           slot;
    int           oldest;
    logic [7:0]   span;
    event_t       code;
    relay_event_t done_ev;
    hit    = -1;
    slot   = -1;
    oldest = -1;
    if (gateway_sh) begin
      code = EV_SUNK;
    end else begin
      for (int e = 0; e < DEPTH; e++) begin
        if (hit < 0 && slot_valid[e] && slot_fid[e] == it.frame_id) begin
          hit = e;
        end
      end
      if (hit >= 0) begin
        if (slot_open[hit]) begin
          fold_candidate(hit, it.hops, it.level);
          code = EV_DUP_BUFFERED;
        end else begin
          code = EV_DUP_IGNORED;
        end
      end else if (it.hops >= hop_limit_sh) begin
        code = EV_HOP_DROP;
      end else begin
        // Take the lowest free slot, else the oldest closed one.
        for (int e = 0; e < DEPTH; e++) begin
          if (slot < 0 && !slot_valid[e]) begin
            slot = e;
          end
        end
        if (slot < 0) begin
          for (int e = 0; e < DEPTH; e++) begin
            if (!slot_open[e] && int'(slot_age[e]) > oldest) begin
              oldest = int'(slot_age[e]);
              slot   = e;
            end
          end
        end
        if (slot < 0) begin
          code = EV_TABLE_FULL;
        end else begin
          for (int e = 0; e < DEPTH; e++) begin
            if (slot_valid[e] && e != slot && slot_age[e] != AGE_MAX) begin
              slot_age[e] = slot_age[e] + 4'd1;
            end
          end
          span = it.wait_len;
          if (span < WAIT_MIN) begin
            span = WAIT_MIN;
          end else if (span > WAIT_MAX) begin
            span = WAIT_MAX;
          end
          slot_valid[slot]      = 1'b1;
          slot_open[slot]       = 1'b1;
          slot_age[slot]        = 4'd0;
          slot_fid[slot]        = it.frame_id;
          slot_ticks[slot]      = span;
          slot_best_hops[slot]  = 8'd0;
          slot_best_level[slot] = 8'd0;
          slot_ties[slot]       = 8'd0;
          fold_candidate(slot, it.hops, it.level);
          code = EV_WINDOW_OPEN;
        end
      end
    end
    done_ev = '{code, it.frame_id, 8'd0, 8'd0, 1'b1};
    pending_events.insert(pending_events.size(), done_ev);
  endfunction

  // A tick closes every window that runs out, in slot order.
  function automatic void predict_tick();
    relay_event_t burst[$];
    relay_event_t r;
    int           n;
    n = 0;
    for (int e = 0; e < DEPTH; e++) begin
      if (slot_valid[e] && slot_open[e]) begin
        if (slot_ticks[e] > 8'd1) begin
          slot_ticks[e] = slot_ticks[e] - 8'd1;
        end else if (n >= int'(MAX_RESULTS)) begin
          // Too many closings this tick: hold the rest for the next one.
          slot_ticks[e] = 8'd1;
        end else begin
          slot_open[e]  = 1'b0;
          slot_ticks[e] = 8'd0;
          r.frame_id = slot_fid[e];
          r.hops     = 8'd0;
          r.level    = 8'd0;
          r.last     = 1'b0;
          if (slot_ties[e] == 8'd0) begin
            r.ev = EV_SPATIAL_DISCARD;
          end else if (slot_ties[e] > 8'd1 && slot_best_level[e] == 8'd0) begin
            r.ev = EV_FILTER_DISCARD;
          end else begin
            r.ev    = EV_FORWARDED;
            r.hops  = (slot_best_hops[e] == SAT8) ? SAT8 : slot_best_hops[e] + 8'd1;
            r.level = own_level_sh;
          end
          burst.insert(burst.size(), r);
          n++;
        end
      end
    end
    if (n > 0) begin
      r      = burst[n - 1];
      r.last = 1'b1;
      burst[n - 1] = r;
    end
    foreach (burst[i]) begin
      pending_events.insert(pending_events.size(), burst[i]);
    end
  endfunction

  function automatic bit any_window_open(logic [31:0] fids[$]);
    bit found;
    found = 1'b0;
    foreach (fids[i]) begin
      for (int e = 0; e < DEPTH; e++) begin
        if (slot_valid[e] && slot_open[e] && slot_fid[e] == fids[i]) begin
          found = 1'b1;
        end
      end
    end
    return found;
  endfunction

  function automatic relay_item_t make_arrival(logic [31:0] fid, logic [7:0] hops,
                                               logic [7:0] lvl, logic [7:0] span);
    relay_item_t it;
    it.kind     = KIND_ARRIVAL;
    it.frame_id = fid;
    it.hops     = hops;
    it.level    = lvl;
    it.wait_len = span;
    return it;
  endfunction

  // Ticks carry random payload; the block must ignore it.
  function automatic relay_item_t make_tick();
    relay_item_t it;
    it          = make_arrival($urandom, 8'($urandom), 8'($urandom), 8'($urandom));
    it.kind     = KIND_TICK;
    return it;
  endfunction

  function automatic relay_item_t make_noise();
    relay_item_t it;
    it = make_arrival($urandom, 8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 1) == 1) begin
      it.kind = KIND_TICK;
    end
    return it;
  endfunction

  // Candidate content by profile: plain, retreat-rejected, level-zero ties,
  // near-saturated hops. An opening arrival stays under the hop limit.
  function automatic relay_item_t make_candidate(int prof, logic [31:0] fid, bit opening);
    relay_item_t it;
    it = make_arrival(fid, 8'($urandom_range(0, 6)), 8'($urandom), 8'($urandom));
    if (opening) begin
      it.wait_len = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 66));
    end
    case (prof)
      1: begin
        if (own_level_sh >= margin_sh) begin
          it.level = 8'($urandom_range(0, 32'(own_level_sh - margin_sh)));
        end
      end
      2: begin
        it.hops  = 8'd0;
        it.level = 8'd0;
      end
      3: begin
        it.hops = 8'($urandom_range(254, 255));
      end
      default: begin
      end
    endcase
    if (opening && it.hops >= hop_limit_sh) begin
      it.hops = 8'($urandom_range(0, 32'(hop_limit_sh) - 1));
    end
    if (opening && prof == 3) begin
      it.hops = hop_limit_sh - 8'd1;
    end
    return it;
  endfunction

  // Drive one item from a falling edge, hold it until the transfer, then
  // advance the shadow model.
  task automatic send_item(relay_item_t it);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.kind         = it.kind;
    item_ch.frame_id     = it.frame_id;
    item_ch.hop_count    = it.hops;
    item_ch.sender_level = it.level;
    item_ch.wait_ticks   = it.wait_len;
    item_ch.valid        = 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    items_sent++;
    if (it.kind == KIND_TICK) begin
      predict_tick();
    end else begin
      predict_arrival(it);
    end
  endtask

  // Hold the input idle until every predicted event has arrived, then let a
  // tick with no closing window finish its walk.
  task automatic drain_results();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Caller makes sure the block is idle.
  task automatic write_register(reg_index_t idx, logic [7:0] value);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(negedge clk);
    wr_en    = 1'b0;
    case (idx)
      REG_OWN_LEVEL:      own_level_sh = value;
      REG_IS_GATEWAY:     gateway_sh   = value[0];
      REG_RETREAT_MARGIN: margin_sh    = value;
      REG_HOP_LIMIT:      hop_limit_sh = value;
      default: ;
    endcase
  endtask

  // Arrival outcomes under the reset register values.
  task automatic test_arrival_outcomes();
    // Open a window with the shortest wait; level 255 passes the retreat test.
    send_item(make_arrival(32'hFFFF_FFFF, 8'd0, 8'd255, 8'd0));
    // Buffer a duplicate that the retreat test rejects, at the largest hops.
    send_item(make_arrival(32'hFFFF_FFFF, 8'd255, 8'd0, 8'd200));
    // Drop at the hop limit and at the largest hop count.
    send_item(make_arrival(32'h0000_0000, 8'd5, 8'd10, 8'd100));
    send_item(make_arrival(32'h0000_0001, 8'd255, 8'd255, 8'd183));
    // Open just under the limit with an over-long wait, clamped to the top.
    send_item(make_arrival(32'h0000_0000, 8'd4, 8'd254, 8'd255));
    // A tick with nothing to close gives no event.
    send_item(make_tick());
    send_item(make_arrival(32'h0000_0000, 8'd0, 8'd255, 8'd61));
  endtask

  // A gateway sinks every arrival, duplicates of open frames included.
  task automatic test_gateway_sink();
    drain_results();
    write_register(REG_IS_GATEWAY, 8'hFF);
    send_item(make_arrival(32'hFFFF_FFFF, 8'd0, 8'd255, 8'd61));
    send_item(make_arrival(32'h0000_0002, 8'd255, 8'd0, 8'd0));
    send_item(make_tick());
    drain_results();
    write_register(REG_IS_GATEWAY, 8'hFE);
  endtask

  // Register extremes: keep everything, then reject everything.
  task automatic test_register_extremes();
    drain_results();
    write_register(REG_OWN_LEVEL, 8'd0);
    write_register(REG_RETREAT_MARGIN, 8'd255);
    write_register(REG_HOP_LIMIT, 8'd255);
    // Level-zero ties on the fewest hops end in a filter discard.
    send_item(make_arrival(32'h0000_0003, 8'd254, 8'd0, 8'd66));
    send_item(make_arrival(32'h0000_0003, 8'd254, 8'd0, 8'd0));
    send_item(make_arrival(32'h0000_0003, 8'd255, 8'd7, 8'd0));
    // Hops of 254 forward as 255.
    send_item(make_arrival(32'h0000_0006, 8'd254, 8'd9, 8'd62));
    drain_results();
    write_register(REG_OWN_LEVEL, 8'd255);
    write_register(REG_RETREAT_MARGIN, 8'd0);
    write_register(REG_HOP_LIMIT, 8'd1);
    send_item(make_arrival(32'h0000_0004, 8'd1, 8'd255, 8'd61));
    send_item(make_arrival(32'h0000_0005, 8'd0, 8'd255, 8'd61));
    send_item(make_arrival(32'h0000_0003, 8'd0, 8'd255, 8'd61));
  endtask

  // One random round: set the registers, open a set of windows with
  // duplicates, then tick until all of them have closed.
  task automatic random_round(int round_no);
    logic [31:0] round_fids[$];
    int          round_prof[$];
    relay_item_t it;
    int          n_frames;
    int          pick;
    int          prof;
    int          ticks_done;
    bit          moved_level;
    quiet_mode  = (round_no % 3 == 2);
    ticks_done  = 0;
    moved_level = 1'b0;
    drain_results();
    case (round_no % 5)
      0: begin
        write_register(REG_OWN_LEVEL, 8'($urandom));
        write_register(REG_RETREAT_MARGIN, 8'($urandom));
        write_register(REG_HOP_LIMIT, 8'($urandom_range(1, 255)));
      end
      1: begin
        write_register(REG_OWN_LEVEL, 8'd0);
        write_register(REG_RETREAT_MARGIN, 8'd255);
        write_register(REG_HOP_LIMIT, 8'd255);
      end
      2: begin
        write_register(REG_OWN_LEVEL, 8'd255);
        write_register(REG_RETREAT_MARGIN, 8'd0);
        write_register(REG_HOP_LIMIT, 8'd1);
      end
      3: begin
        write_register(REG_OWN_LEVEL, 8'($urandom));
        write_register(REG_RETREAT_MARGIN, 8'($urandom_range(0, 32'(own_level_sh))));
        write_register(REG_HOP_LIMIT, 8'($urandom_range(2, 8)));
      end
      default: begin
        // Margin above own level keeps level-zero candidates.
        write_register(REG_OWN_LEVEL, 8'($urandom_range(0, 40)));
        write_register(REG_RETREAT_MARGIN, 8'($urandom_range(41, 255)));
        write_register(REG_HOP_LIMIT, 8'd255);
      end
    endcase
    write_register(REG_IS_GATEWAY, {7'($urandom), 1'b0});

    // Flood rounds open more frames than the table holds.
    n_frames = (round_no % 4 == 3) ? DEPTH + 2 : $urandom_range(2, 6);
    for (int i = 0; i < n_frames; i++) begin
      prof = (i + round_no) % 4;
      it   = make_candidate(prof, $urandom, 1'b1);
      round_fids.insert(round_fids.size(), it.frame_id);
      round_prof.insert(round_prof.size(), prof);
      send_item(it);
      repeat ($urandom_range(0, 2)) begin
        pick = $urandom_range(0, round_fids.size() - 1);
        send_item(make_candidate(round_prof[pick], round_fids[pick], 1'b0));
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_noise());
      end
    end

    // Turn the node into a gateway with windows still open.
    if (round_no % 4 == 1) begin
      drain_results();
      write_register(REG_IS_GATEWAY, {7'($urandom), 1'b1});
      repeat (3) begin
        pick = $urandom_range(0, round_fids.size() - 1);
        send_item(make_candidate(round_prof[pick], round_fids[pick], 1'b0));
      end
    end

    // Tick the windows down; late duplicates land on either side of a close.
    while (any_window_open(round_fids)) begin
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, round_fids.size() - 1);
        send_item(make_candidate(round_prof[pick], round_fids[pick], 1'b0));
      end else if ($urandom_range(0, 19) == 0) begin
        send_item(make_noise());
      end else begin
        send_item(make_tick());
        ticks_done++;
      end
      // Move the own level mid-window: retreat tests already made stand.
      if (round_no % 2 == 0 && ticks_done == 30 && !moved_level) begin
        moved_level = 1'b1;
        drain_results();
        write_register(REG_OWN_LEVEL, 8'($urandom));
      end
    end
  endtask

  // Result side: hold ready low at random before each transfer, except in quiet mode.
  initial begin : result_sink
    int stall;
    result_ch.ready = 1'b0;
    forever begin
      stall = quiet_mode ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        result_ch.ready = 1'b0;
      end
      @(negedge clk);
      result_ch.ready = 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
    end
  end

  // Compare each result transfer with the oldest predicted event.
  always @(posedge clk) begin : check_results
    relay_event_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected result: ev=%0d fid=%h hops=%0d lvl=%0d last=%0b",
                   result_ch.event_res, result_ch.out_frame_id, result_ch.out_hop_count,
                   result_ch.out_level, result_ch.last);
        end
      end else begin
        want = pending_events.pop_front();
        if (result_ch.event_res !== want.ev || result_ch.out_frame_id !== want.frame_id ||
            result_ch.out_hop_count !== want.hops || result_ch.out_level !== want.level ||
            result_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch: expected ev=%0d fid=%h hops=%0d lvl=%0d last=%0b",
                     want.ev, want.frame_id, want.hops, want.level, want.last);
            $display("          actual   ev=%0d fid=%h hops=%0d lvl=%0d last=%0b",
                     result_ch.event_res, result_ch.out_frame_id, result_ch.out_hop_count,
                     result_ch.out_level, result_ch.last);
          end
        end
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main_sequence
    int round_no;
    rst                  = 1'b1;
    wr_en                = 1'b0;
    wr_index             = REG_OWN_LEVEL;
    wr_data              = 8'd0;
    item_ch.valid        = 1'b0;
    item_ch.kind         = KIND_ARRIVAL;
    item_ch.frame_id     = 32'd0;
    item_ch.hop_count    = 8'd0;
    item_ch.sender_level = 8'd0;
    item_ch.wait_ticks   = 8'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_arrival_outcomes();
    test_gateway_sink();
    test_register_extremes();

    round_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      random_round(round_no);
      round_no++;
    end

    // Hold off until every predicted event is in and the last walk is done.
    drain_results();
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
